### design/spatial_grid_cell_grouping_assert.svh
`ifndef SPATIAL_GRID_CELL_GROUPING_ASSERT_SVH
`define SPATIAL_GRID_CELL_GROUPING_ASSERT_SVH
// implication checked on every clock, held off in reset
`define SGCG_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// next-cycle implication
`define SGCG_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

### design/sgcg_pkg.sv
package sgcg_pkg;
   localparam int CoordWidth = 32;
   localparam int CellWidth  = 16;
   localparam int CfgWidth   = 31;

   typedef struct packed {
      logic signed [CellWidth-1:0] cx;
      logic signed [CellWidth-1:0] cy;
      logic signed [CellWidth-1:0] cz;
      logic                        first;
   } cell_item_type;
endpackage

### design/sgcg_front.sv
// Front: three serial floor divisions, then push the cell index to the queue.
module sgcg_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [sgcg_pkg::CoordWidth-1:0] pos_x,
   input  logic signed [sgcg_pkg::CoordWidth-1:0] pos_y,
   input  logic signed [sgcg_pkg::CoordWidth-1:0] pos_z,
   input  logic                                   first,
   input  logic [sgcg_pkg::CfgWidth-1:0]          width,
   input  logic                                   q_full,
   output logic                                   front_busy,
   output logic                                   q_push,
   output sgcg_pkg::cell_item_type                q_data
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_PUSH = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  axis_ff, axis_in;
   logic [5:0]  bit_ff, bit_in;
   logic [31:0] mag_ff [3];
   logic        neg_ff [3];
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic signed [15:0] idx_ff [3];
   logic        first_ff;
   logic [30:0] w;
   logic [32:0] trial;
   logic [31:0] q_next, r_next;
   logic [32:0] qf;
   logic signed [33:0] sq;
   logic signed [15:0] sat;

   assign w = (width == '0) ? 31'd1 : width;
   assign trial = {rem_ff, quo_ff[31]} - {2'b00, w};
   assign front_busy = (state_ff != S_IDLE);
   assign q_push = (state_ff == S_PUSH) && !q_full;
   assign q_data = '{cx: idx_ff[0], cy: idx_ff[1], cz: idx_ff[2], first: first_ff};

   always_comb begin
      // restoring step over |x|
      if (!trial[32]) r_next = trial[31:0];
      else r_next = {rem_ff[30:0], quo_ff[31]};
      q_next = {quo_ff[30:0], !trial[32]};
      // floor for negative with remainder: -(q+1)
      qf = {1'b0, q_next} + {32'd0, (neg_ff[axis_ff] && r_next != '0)};
      sq = neg_ff[axis_ff] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
      if (sq > 34'sd32767) sat = 16'sd32767;
      else if (sq < -34'sd32768) sat = -16'sd32768;
      else sat = sq[15:0];
   end

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      bit_in = bit_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DIV;
               axis_in = 2'd0;
               bit_in = 6'd0;
               quo_in = pos_x[31] ? 32'(-pos_x) : pos_x;
               rem_in = '0;
            end
         end
         S_DIV: begin
            quo_in = q_next;
            rem_in = r_next;
            bit_in = bit_ff + 6'd1;
            if (bit_ff == 6'd31) begin
               bit_in = '0;
               rem_in = '0;
               if (axis_ff == 2'd2) state_in = S_PUSH;
               else begin
                  axis_in = axis_ff + 2'd1;
                  quo_in = mag_ff[axis_ff + 2'd1];
               end
            end
         end
         S_PUSH: if (!q_full) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      axis_ff <= axis_in;
      bit_ff <= bit_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (state_ff == S_IDLE && start) begin
         mag_ff[0] <= pos_x[31] ? 32'(-pos_x) : pos_x;
         mag_ff[1] <= pos_y[31] ? 32'(-pos_y) : pos_y;
         mag_ff[2] <= pos_z[31] ? 32'(-pos_z) : pos_z;
         neg_ff[0] <= pos_x[31];
         neg_ff[1] <= pos_y[31];
         neg_ff[2] <= pos_z[31];
         first_ff <= first;
      end
      if (state_ff == S_DIV && bit_ff == 6'd31) idx_ff[axis_ff] <= sat;
   end
endmodule

### design/sgcg_queue.sv
// Two-entry queue between front and back.
module sgcg_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sgcg_pkg::cell_item_type push_data,
   input  logic                    pop,
   output logic                    full,
   output logic                    not_empty,
   output sgcg_pkg::cell_item_type pop_data
);
   sgcg_pkg::cell_item_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule

### design/sgcg_back.sv
// Back: linear table search, append on miss, center multiply, one result beat.
module sgcg_back #(
   parameter int MAX_GROUPS = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   input  sgcg_pkg::cell_item_type                q_data,
   input  logic [sgcg_pkg::CfgWidth-1:0]          width,
   output logic                                   q_pop,
   output logic                                   back_busy,
   output logic                                   rsp_valid,
   output logic [31:0]                            rsp_point_number,
   output logic [7:0]                             rsp_group_id,
   output logic                                   rsp_new_group,
   output logic                                   rsp_table_full,
   output logic signed [sgcg_pkg::CellWidth-1:0]  rsp_cell_x,
   output logic signed [sgcg_pkg::CellWidth-1:0]  rsp_cell_y,
   output logic signed [sgcg_pkg::CellWidth-1:0]  rsp_cell_z,
   output logic signed [sgcg_pkg::CoordWidth-1:0] rsp_center_x,
   output logic signed [sgcg_pkg::CoordWidth-1:0] rsp_center_y,
   output logic signed [sgcg_pkg::CoordWidth-1:0] rsp_center_z
);
   localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CW = $clog2(MAX_GROUPS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]    state_ff;
   logic [47:0]   table_mem [MAX_GROUPS];
   logic [47:0]   rd_ff;
   logic [CW-1:0] count_ff, scan_ff;
   logic [31:0]   pnum_ff;
   sgcg_pkg::cell_item_type item_ff;
   logic [AW-1:0] gid_ff;
   logic          new_ff, full_ff, found_ff;
   logic [1:0]    axis_ff;
   logic signed [31:0] ctr_ff [3];
   logic [30:0]   w;
   logic signed [15:0] idx;
   logic signed [48:0] prod;
   logic signed [48:0] half;

   assign w = (width == '0) ? 31'd1 : width;
   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign back_busy = (state_ff != S_IDLE);

   always_comb begin
      unique case (axis_ff)
         2'd0: idx = item_ff.cx;
         2'd1: idx = item_ff.cy;
         default: idx = item_ff.cz;
      endcase
      prod = $signed({18'd0, w}) * $signed({{32{idx[15]}}, idx, 1'b1});
      half = prod >>> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pnum_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               item_ff <= q_data;
               scan_ff <= '0;
               found_ff <= 1'b0;
               new_ff <= 1'b0;
               full_ff <= 1'b0;
               if (q_data.first) begin
                  count_ff <= '0;
                  rsp_point_number <= '0;
                  pnum_ff <= 32'd1;
               end else begin
                  rsp_point_number <= pnum_ff;
                  pnum_ff <= pnum_ff + 32'd1;
               end
               state_ff <= S_READ;
            end
            S_READ: begin
               if (scan_ff < count_ff) begin
                  rd_ff <= table_mem[scan_ff[AW-1:0]];
                  state_ff <= S_CMP;
               end else begin
                  if (count_ff < CW'(MAX_GROUPS)) begin
                     table_mem[count_ff[AW-1:0]] <= {item_ff.cx, item_ff.cy, item_ff.cz};
                     gid_ff <= count_ff[AW-1:0];
                     count_ff <= count_ff + CW'(1);
                     new_ff <= 1'b1;
                     found_ff <= 1'b1;
                  end else full_ff <= 1'b1;
                  axis_ff <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_CMP: begin
               if (rd_ff == {item_ff.cx, item_ff.cy, item_ff.cz}) begin
                  gid_ff <= scan_ff[AW-1:0];
                  found_ff <= 1'b1;
                  axis_ff <= '0;
                  state_ff <= S_MUL;
               end else begin
                  scan_ff <= scan_ff + CW'(1);
                  state_ff <= S_READ;
               end
            end
            S_MUL: begin
               if (half > 49'sh7FFFFFFF) ctr_ff[axis_ff] <= 32'sh7FFFFFFF;
               else if (half < -49'sh80000000) ctr_ff[axis_ff] <= 32'sh80000000;
               else ctr_ff[axis_ff] <= half[31:0];
               axis_ff <= axis_ff + 2'd1;
               if (axis_ff == 2'd2) state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      if (state_ff == S_OUT) begin
         rsp_group_id <= found_ff ? 8'(gid_ff) : 8'd0;
         rsp_new_group <= new_ff;
         rsp_table_full <= full_ff;
         rsp_cell_x <= item_ff.cx;
         rsp_cell_y <= item_ff.cy;
         rsp_cell_z <= item_ff.cz;
         rsp_center_x <= found_ff ? ctr_ff[0] : 32'sd0;
         rsp_center_y <= found_ff ? ctr_ff[1] : 32'sd0;
         rsp_center_z <= found_ff ? ctr_ff[2] : 32'sd0;
      end
   end
endmodule

### design/spatial_grid_cell_grouping.sv
// Bins Q16.16 points into cubic cells and groups them in first-seen order.
// The front takes a point when busy is low and holds busy high through three
// 32-step serial divisions and a push state, so it takes no new point until it
// is done with the last. It hands the cell index through a two-entry queue to
// the back, which scans the group table one entry at a time (a read state, then
// a compare state), then computes the three centers one axis at a time. When the
// back is slower the queue fills and the front keeps busy high in its push state
// until a slot frees. One result beat per point on rsp_valid; the receiver
// cannot stall.
// The group table needs no clearing after reset.
module spatial_grid_cell_grouping #(
   parameter int MAX_GROUPS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic               req_first,
   input  logic               csr_we,
   input  logic [30:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [31:0]        rsp_point_number,
   output logic [7:0]         rsp_group_id,
   output logic               rsp_new_group,
   output logic               rsp_table_full,
   output logic signed [15:0] rsp_cell_x,
   output logic signed [15:0] rsp_cell_y,
   output logic signed [15:0] rsp_cell_z,
   output logic signed [31:0] rsp_center_x,
   output logic signed [31:0] rsp_center_y,
   output logic signed [31:0] rsp_center_z
);
   logic [30:0] width_ff;
   logic q_full, q_push, q_pop, q_ne, front_busy, back_busy;
   sgcg_pkg::cell_item_type q_in, q_out;

   always_ff @(posedge clock) begin
      if (reset) width_ff <= 31'd65536;
      else if (csr_we) width_ff <= csr_wdata;
   end

   assign busy = front_busy;

   sgcg_front u_front (
      .clock, .reset, .start, .pos_x(req_pos_x), .pos_y(req_pos_y),
      .pos_z(req_pos_z), .first(req_first), .width(width_ff), .q_full,
      .front_busy, .q_push, .q_data(q_in)
   );

   sgcg_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .pop(q_pop),
      .full(q_full), .not_empty(q_ne), .pop_data(q_out)
   );

   sgcg_back #(.MAX_GROUPS(MAX_GROUPS)) u_back (
      .clock, .reset, .q_valid(q_ne), .q_data(q_out), .width(width_ff),
      .q_pop, .back_busy, .rsp_valid, .rsp_point_number, .rsp_group_id,
      .rsp_new_group, .rsp_table_full, .rsp_cell_x, .rsp_cell_y, .rsp_cell_z,
      .rsp_center_x, .rsp_center_y, .rsp_center_z
   );
endmodule

### design/sgcg_checker.sv
`include "spatial_grid_cell_grouping_assert.svh"
module sgcg_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_new_group,
   input logic        rsp_table_full,
   input logic [7:0]  rsp_group_id,
   input logic [31:0] rsp_center_x
);
   `SGCG_ASSERT_IMPL(a_excl, clock, reset, rsp_valid, !(rsp_new_group && rsp_table_full))
   `SGCG_ASSERT_IMPL(a_fullz, clock, reset, rsp_valid && rsp_table_full,
      rsp_group_id == 8'd0 && rsp_center_x == 32'd0)
   `SGCG_ASSERT_NEXT(a_take, clock, reset, start && !busy, busy)
   `SGCG_ASSERT_NEXT(a_single, clock, reset, rsp_valid, !rsp_valid)
endmodule

bind spatial_grid_cell_grouping sgcg_checker u_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_new_group, .rsp_table_full,
   .rsp_group_id, .rsp_center_x
);
